@@ hw/rtl/node_adjacency_list_builder_core_macros.svh @@
// assertion macros for the adjacency list builder
`ifndef NODE_ADJACENCY_LIST_BUILDER_CORE_MACROS_SVH
`define NODE_ADJACENCY_LIST_BUILDER_CORE_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define NALB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication, checked on the rising clock edge outside reset
`define NALB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

@@ hw/rtl/nalb_pkg.sv @@
// shared constants and types of the adjacency list builder
package nalb_pkg;

  localparam int unsigned NODE_COUNT    = 4096;
  localparam int unsigned MAX_NEIGHBORS = 64;

  localparam int unsigned NODE_W  = 12;
  localparam int unsigned SLOT_W  = 18;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned SEEN_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned ML_AW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  // seen bitmap port request
  typedef struct packed {
    logic               we;
    logic [SEEN_AW-1:0] waddr;
    logic               wdata;
    logic               re;
    logic [SEEN_AW-1:0] raddr;
  } seen_req_t;

  // marked list port request
  typedef struct packed {
    logic              we;
    logic [ML_AW-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [ML_AW-1:0]  raddr;
  } ml_req_t;

  // controller status seen by the top level
  typedef struct packed {
    logic clearing;
    logic unmarking;
  } ctrl_status_t;

endpackage

@@ hw/rtl/node_adjacency_list_builder_core.sv @@
// top level of the adjacency list builder: sequencer plus bitmap and marked list rams
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | center_node, candidate_node, last_of_center
//   out     | output    | out_valid/out_stall| is_new_neighbor, neighbor_node, slot,
//           |           |                    | neighbor_count, center_done, overflow
//
// each item reads the seen bitmap in its accept cycle, then the writeback state
// decides, writes the bitmap and marked list back and loads the output register
// an item with last_of_center that stored n > 0 neighbors for its center is followed
// by a sweep of the marked list that clears their bitmap bits
// after reset all 4096 bitmap entries are cleared one entry a cycle, in_stall high
// an item whose result finds the output register held under out_stall waits in the
// writeback cycle, and in_stall stays high until that register frees
`include "node_adjacency_list_builder_core_macros.svh"

module node_adjacency_list_builder_core (
  input  logic                         clk,
  input  logic                         rst,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nalb_pkg::NODE_W-1:0]  center_node,
  input  logic [nalb_pkg::NODE_W-1:0]  candidate_node,
  input  logic                         last_of_center,
  // result item channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_new_neighbor,
  output logic [nalb_pkg::NODE_W-1:0]  neighbor_node,
  output logic [nalb_pkg::SLOT_W-1:0]  slot,
  output logic [nalb_pkg::COUNT_W-1:0] neighbor_count,
  output logic                         center_done,
  output logic                         overflow
);

  nalb_pkg::seen_req_t          seen_req;
  nalb_pkg::ml_req_t            ml_req;
  nalb_pkg::ctrl_status_t       status;
  logic                         seen_rdata;
  logic [nalb_pkg::NODE_W-1:0]  ml_rdata;

  // sequencer: bitmap read-modify-write, slot and count, unmark sweep
  nalb_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .center_node     (center_node),
    .candidate_node  (candidate_node),
    .last_of_center  (last_of_center),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_new_neighbor (is_new_neighbor),
    .neighbor_node   (neighbor_node),
    .slot            (slot),
    .neighbor_count  (neighbor_count),
    .center_done     (center_done),
    .overflow        (overflow),
    .seen_req        (seen_req),
    .seen_rdata      (seen_rdata),
    .ml_req          (ml_req),
    .ml_rdata        (ml_rdata),
    .status          (status)
  );

  // seen bitmap, one bit per node, cleared by the sweep after reset
  nalb_ram #(
    .DEPTH (nalb_pkg::NODE_COUNT),
    .WIDTH (1)
  ) u_seen (
    .clk   (clk),
    .we    (seen_req.we),
    .waddr (seen_req.waddr),
    .wdata (seen_req.wdata),
    .re    (seen_req.re),
    .raddr (seen_req.raddr),
    .rdata (seen_rdata)
  );

  // nodes marked for the current center, in arrival order
  nalb_ram #(
    .DEPTH (nalb_pkg::MAX_NEIGHBORS),
    .WIDTH (nalb_pkg::NODE_W)
  ) u_marked (
    .clk   (clk),
    .we    (ml_req.we),
    .waddr (ml_req.waddr),
    .wdata (ml_req.wdata),
    .re    (ml_req.re),
    .raddr (ml_req.raddr),
    .rdata (ml_rdata)
  );

  // no item is taken while the bitmap is being cleared or unmarked
  `NALB_ASSERT_IMPLY(a_stall_busy, status.clearing || status.unmarking, in_stall)
  // the cycle after an accept is the writeback cycle, which takes no item
  `NALB_ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall)
  // a dropped neighbor is never also reported new
  `NALB_ASSERT_IMPLY(a_new_xor_ovf, out_valid, !(is_new_neighbor && overflow))
  // only a new neighbor carries a slot, and the count stays within the limit
  `NALB_ASSERT_IMPLY(a_slot_count, out_valid,
    (is_new_neighbor || slot == '0) && (32'(neighbor_count) <= nalb_pkg::MAX_NEIGHBORS))

endmodule

@@ hw/rtl/nalb_ram.sv @@
// generic simple dual-port ram with registered read data
module nalb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/nalb_ctrl.sv @@
// sequencer and datapath: bitmap read-modify-write, slot math, unmark sweep
module nalb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nalb_pkg::NODE_W-1:0]  center_node,
  input  logic [nalb_pkg::NODE_W-1:0]  candidate_node,
  input  logic                         last_of_center,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_new_neighbor,
  output logic [nalb_pkg::NODE_W-1:0]  neighbor_node,
  output logic [nalb_pkg::SLOT_W-1:0]  slot,
  output logic [nalb_pkg::COUNT_W-1:0] neighbor_count,
  output logic                         center_done,
  output logic                         overflow,
  output nalb_pkg::seen_req_t          seen_req,
  input  logic                         seen_rdata,
  output nalb_pkg::ml_req_t            ml_req,
  input  logic [nalb_pkg::NODE_W-1:0]  ml_rdata,
  output nalb_pkg::ctrl_status_t       status
);

  localparam logic [1:0] ST_CLR    = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_RD     = 2'd2;
  localparam logic [1:0] ST_UNMARK = 2'd3;

  logic [1:0]                     state;
  logic [nalb_pkg::SEEN_AW-1:0]   clr_addr;
  logic [nalb_pkg::NODE_W-1:0]    cen;
  logic [nalb_pkg::NODE_W-1:0]    cand;
  logic                           last;
  logic [nalb_pkg::COUNT_W-1:0]   count;
  logic [nalb_pkg::SLOT_W-1:0]    offset;
  logic [nalb_pkg::COUNT_W-1:0]   um_idx;
  logic [nalb_pkg::COUNT_W-1:0]   um_n;
  logic                           pend;

  logic                           accept;
  logic                           out_ready;
  logic                           hit;
  logic                           room;
  logic                           is_new;
  logic [nalb_pkg::COUNT_W-1:0]   count_next;
  logic                           um_more;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  // output register is free or being drained at this edge
  assign out_ready = !out_valid || !out_stall;

  assign hit = (cand != cen) && (32'(cand) < nalb_pkg::NODE_COUNT) && !seen_rdata;
  assign room = 32'(count) < nalb_pkg::MAX_NEIGHBORS;
  assign is_new = hit && room;
  assign count_next = count + nalb_pkg::COUNT_W'(is_new);
  assign um_more = um_idx < um_n;

  assign status.clearing  = (state == ST_CLR);
  assign status.unmarking = (state == ST_UNMARK);

  // memory requests
  always_comb begin
    seen_req.we    = 1'b0;
    seen_req.waddr = clr_addr;
    seen_req.wdata = 1'b0;
    seen_req.re    = accept;
    seen_req.raddr = nalb_pkg::SEEN_AW'(candidate_node);
    unique case (state)
      ST_CLR: begin
        seen_req.we = 1'b1;
      end
      ST_IDLE: begin
        seen_req.we = 1'b0;
      end
      ST_RD: begin
        seen_req.we    = is_new && out_ready;
        seen_req.waddr = nalb_pkg::SEEN_AW'(cand);
        seen_req.wdata = 1'b1;
      end
      ST_UNMARK: begin
        seen_req.we    = pend;
        seen_req.waddr = nalb_pkg::SEEN_AW'(ml_rdata);
      end
    endcase
  end

  assign ml_req.we    = (state == ST_RD) && is_new && out_ready;
  assign ml_req.waddr = nalb_pkg::ML_AW'(count);
  assign ml_req.wdata = cand;
  assign ml_req.re    = (state == ST_UNMARK) && um_more;
  assign ml_req.raddr = nalb_pkg::ML_AW'(um_idx);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      count     <= '0;
      offset    <= '0;
      um_idx    <= '0;
      um_n      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == nalb_pkg::SEEN_AW'(nalb_pkg::NODE_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          // hold the item here while the previous result is stalled
          if (out_ready) begin
            out_valid <= 1'b1;
            if (last) begin
              offset <= offset + nalb_pkg::SLOT_W'(count_next);
              count  <= '0;
              um_n   <= count_next;
              um_idx <= '0;
              pend   <= 1'b0;
              state  <= (count_next != '0) ? ST_UNMARK : ST_IDLE;
            end else begin
              count <= count_next;
              state <= ST_IDLE;
            end
          end
        end
        ST_UNMARK: begin
          pend <= um_more;
          if (um_more) begin
            um_idx <= um_idx + 1'b1;
          end
          if (!um_more && !pend) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cen  <= center_node;
      cand <= candidate_node;
      last <= last_of_center;
    end
    if ((state == ST_RD) && out_ready) begin
      is_new_neighbor <= is_new;
      neighbor_node   <= cand;
      slot            <= is_new ? (offset + nalb_pkg::SLOT_W'(count)) : '0;
      neighbor_count  <= count_next;
      center_done     <= last;
      overflow        <= hit && !room;
    end
  end

endmodule
